// ===== hw/rtl/mbps_pkg.sv =====
// Shared constants and types of the masked byte pattern scanner.
`default_nettype none

package mbps_pkg;

   // Defaults for the top-level parameters.
   localparam int MAX_PATTERN_DEFAULT  = 16;
   localparam int ADDRESS_BITS_DEFAULT = 48;

   // Pattern bytes that the registers can hold; later positions are wildcards.
   localparam int PATTERN_BYTES = 16;

   // Field widths.
   localparam int DATA_W    = 8;
   localparam int BASE_W    = 48;
   localparam int REGION_W  = 16;
   localparam int HIT_ADDR_W = 48;
   localparam int LEN_W     = 5;
   localparam int HITS_W    = 24;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_W     = 64;

   localparam int REQ_TDATA_W = 72;
   localparam int RSP_TDATA_W = 64;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_PATTERN_LOW  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PATTERN_HIGH = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CARE_MASK    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PATTERN_LEN  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_HITS     = 3'd4;

   // Register reset values.
   localparam logic [PATTERN_BYTES-1:0] CARE_MASK_RESET = 16'hFFFF;
   localparam logic [HITS_W-1:0]        MAX_HITS_RESET  = 24'hFFFFFF;

   // Pattern settings handed to the window compare.
   typedef struct packed {
      logic [PATTERN_BYTES*DATA_W-1:0] pattern;
      logic [PATTERN_BYTES-1:0]        care;
      logic [LEN_W-1:0]                len;
   } cfg_type;

endpackage

`default_nettype wire

// ===== hw/rtl/mbps_window_match.sv =====
// Masked compare of the newest window bytes against the configured pattern.
`default_nettype none

module mbps_window_match #(
   parameter int MAX_PATTERN = mbps_pkg::MAX_PATTERN_DEFAULT
) (
   input  logic [7:0]                           window_i [MAX_PATTERN],
   input  logic [$clog2(MAX_PATTERN+1)-1:0]     count_i,
   input  mbps_pkg::cfg_type                    cfg_i,
   output logic                                 match_o
);
   import mbps_pkg::*;

   localparam int IdxW     = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int PatBytes = (MAX_PATTERN < PATTERN_BYTES) ? MAX_PATTERN : PATTERN_BYTES;

   logic len_ok;
   logic count_ok;
   logic bytes_ok;

   assign len_ok   = (cfg_i.len != '0) && (int'(cfg_i.len) <= MAX_PATTERN);
   assign count_ok = int'(count_i) >= int'(cfg_i.len);

   // Pattern byte j lines up with window slot MAX_PATTERN - len + j.
   always_comb begin
      int pos;
      logic [IdxW-1:0] sel;
      bytes_ok = 1'b1;
      pos      = 0;
      sel      = '0;
      for (int j = 0; j < PatBytes; j++) begin
         pos = MAX_PATTERN - int'(cfg_i.len) + j;
         sel = IdxW'(pos);
         if ((j < int'(cfg_i.len)) && cfg_i.care[j] &&
             (window_i[sel] != cfg_i.pattern[j*DATA_W +: DATA_W])) begin
            bytes_ok = 1'b0;
         end
      end
   end

   assign match_o = len_ok && count_ok && bytes_ok;

endmodule

`default_nettype wire

// ===== hw/rtl/masked_byte_pattern_scanner.sv =====
// Masked byte pattern scanner: streams region bytes and reports pattern hits.
//
// The scanner takes one byte of region contents per clock and keeps the last
// MAX_PATTERN bytes of the current region in a shift window. A request with the
// region-first flag in tuser restarts the window count and loads the region's
// base address and index. Once a byte is in the window register, the newest
// pattern_length bytes are compared in parallel against the pattern (cleared
// care_mask bits match anything) and a hit is loaded into the result register
// when that register is free; a hit passes the window and result registers on
// its way out, and a new request is taken every clock while the response side
// keeps up. A response carries the address of the matching window's first byte
// and the region index. At most max_hits hits are reported; a pattern_length of
// zero or above MAX_PATTERN gives none. The user must write registers only while
// the scanner is idle; the scanner itself does not enforce this.
`default_nettype none

module masked_byte_pattern_scanner #(
   parameter int MAX_PATTERN  = mbps_pkg::MAX_PATTERN_DEFAULT,
   parameter int ADDRESS_BITS = mbps_pkg::ADDRESS_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,

   input  logic                               req_tvalid,
   output logic                               req_tready,
   // data_byte [7:0], region_base [55:8], region_number [71:56]
   input  logic [mbps_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // region_first
   input  logic                               req_tuser,

   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // hit_address [47:0], hit_region [63:48]
   output logic [mbps_pkg::RSP_TDATA_W-1:0]   rsp_tdata,

   input  logic                               csr_we,
   input  logic [mbps_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mbps_pkg::CSR_W-1:0]         csr_wdata
);
   import mbps_pkg::*;

   localparam int CntW  = $clog2(MAX_PATTERN + 1);
   localparam int AddrW = ADDRESS_BITS;

   // Configuration registers.
   logic [CSR_W-1:0]         pattern_low_ff;
   logic [CSR_W-1:0]         pattern_high_ff;
   logic [PATTERN_BYTES-1:0] care_mask_ff;
   logic [LEN_W-1:0]         pattern_len_ff;
   logic [HITS_W-1:0]        max_hits_ff;
   cfg_type                  cfg;

   // Scan state.
   logic [7:0]          window_ff [MAX_PATTERN];
   logic [7:0]          window_in [MAX_PATTERN];
   logic [CntW-1:0]     count_ff;
   logic [CntW-1:0]     count_in;
   logic [AddrW-1:0]    next_addr_ff;
   logic [AddrW-1:0]    next_addr_in;
   logic [AddrW-1:0]    item_addr;
   logic [REGION_W-1:0] region_ff;
   logic [REGION_W-1:0] region_in;
   logic [HITS_W-1:0]   hits_ff;
   logic [HITS_W-1:0]   hits_in;

   // Compare stage and result register.
   logic                  eval_ff;
   logic                  eval_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [HIT_ADDR_W-1:0] rsp_addr_ff;
   logic [HIT_ADDR_W-1:0] rsp_addr_in;
   logic [REGION_W-1:0]   rsp_region_ff;
   logic [REGION_W-1:0]   rsp_region_in;

   logic       req_accept;
   logic       out_free;
   logic       advance;
   logic       match;
   logic       fire;
   logic [7:0] data_byte;
   logic       region_first;

   assign data_byte    = req_tdata[7:0];
   assign region_first = req_tuser;

   // Configuration port.
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff  <= '0;
         pattern_high_ff <= '0;
         care_mask_ff    <= CARE_MASK_RESET;
         pattern_len_ff  <= '0;
         max_hits_ff     <= MAX_HITS_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_PATTERN_LOW:  pattern_low_ff  <= csr_wdata;
            REG_PATTERN_HIGH: pattern_high_ff <= csr_wdata;
            REG_CARE_MASK:    care_mask_ff    <= csr_wdata[PATTERN_BYTES-1:0];
            REG_PATTERN_LEN:  pattern_len_ff  <= csr_wdata[LEN_W-1:0];
            REG_MAX_HITS:     max_hits_ff     <= csr_wdata[HITS_W-1:0];
            default: ;
         endcase
      end
   end

   assign cfg.pattern = {pattern_high_ff, pattern_low_ff};
   assign cfg.care    = care_mask_ff;
   assign cfg.len     = pattern_len_ff;

   // Handshake. A pending compare holds the window until it can move on.
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = eval_ff && out_free;
   assign req_tready = !eval_ff || out_free;
   assign req_accept = req_tvalid && req_tready;

   // Window and region bookkeeping for an accepted request.
   assign item_addr    = region_first ? AddrW'(req_tdata[55:8]) : next_addr_ff;
   assign next_addr_in = req_accept ? item_addr + AddrW'(1) : next_addr_ff;
   assign region_in    = (req_accept && region_first) ? req_tdata[71:56] : region_ff;

   always_comb begin
      count_in = count_ff;
      if (req_accept) begin
         if (region_first) begin
            count_in = CntW'(1);
         end else if (count_ff != CntW'(MAX_PATTERN)) begin
            count_in = count_ff + CntW'(1);
         end
      end
   end

   always_comb begin
      for (int k = 0; k < MAX_PATTERN; k++) begin
         window_in[k] = window_ff[k];
      end
      if (req_accept) begin
         for (int k = 0; k < MAX_PATTERN - 1; k++) begin
            window_in[k] = window_ff[k+1];
         end
         window_in[MAX_PATTERN-1] = data_byte;
      end
   end

   assign eval_in = req_accept ? 1'b1 : (advance ? 1'b0 : eval_ff);

   mbps_window_match #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_match (
      .window_i (window_ff),
      .count_i  (count_ff),
      .cfg_i    (cfg),
      .match_o  (match)
   );

   assign fire    = advance && match && (hits_ff < max_hits_ff);
   assign hits_in = fire ? hits_ff + HITS_W'(1) : hits_ff;

   // The window start is the next address less the pattern length.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_region_in = rsp_region_ff;
      if (advance) begin
         rsp_valid_in  = fire;
         rsp_addr_in   = HIT_ADDR_W'(next_addr_ff - AddrW'(cfg.len));
         rsp_region_in = region_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         next_addr_ff <= '0;
         region_ff    <= '0;
         hits_ff      <= '0;
         eval_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         next_addr_ff <= next_addr_in;
         region_ff    <= region_in;
         hits_ff      <= hits_in;
         eval_ff      <= eval_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < MAX_PATTERN; k++) begin
         window_ff[k] <= window_in[k];
      end
      rsp_addr_ff   <= rsp_addr_in;
      rsp_region_ff <= rsp_region_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_region_ff, rsp_addr_ff};

   // A new result only ever comes from a request that was waiting for compare.
   a_result_from_compare: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(eval_ff))
      else $error("result appeared without a pending compare");

   // Requests are held off only while a compare waits behind a stalled result.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (eval_ff && rsp_valid_ff && !rsp_tready))
      else $error("request stalled without cause");

   // Every reported hit is counted exactly once.
   a_hit_counted: assert property (@(posedge clock) disable iff (reset)
      fire |=> (hits_ff == $past(hits_ff) + HITS_W'(1)) && rsp_valid_ff)
      else $error("hit not counted or not presented");

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking testbench for the masked byte pattern scanner.
`timescale 1ns / 100ps

module testbench;

   import mbps_pkg::*;

   localparam int WINDOW     = MAX_PATTERN_DEFAULT;
   localparam int IDLE_LIMIT = 2000;
   localparam int PHASES     = 12;
   localparam int PHASE_SIZE = 135;

   typedef struct packed {
      logic [REGION_W-1:0]   region;
      logic [HIT_ADDR_W-1:0] address;
   } scan_hit_type;

   // Predicts the hits of the scanner and checks the responses against them.
   class hit_scoreboard_type;
      bit [DATA_W-1:0]     pattern [PATTERN_BYTES];
      bit [PATTERN_BYTES-1:0] care;
      bit [LEN_W-1:0]      length;
      bit [HITS_W-1:0]     hit_limit;

      bit [DATA_W-1:0]     window [WINDOW];
      int unsigned         fill;
      bit [BASE_W-1:0]     next_addr;
      bit [REGION_W-1:0]   region;
      bit [HITS_W-1:0]     hit_count;

      scan_hit_type        expected_hits [$];
      int unsigned         mismatches;
      int unsigned         hits_checked;

      function new();
         foreach (pattern[k]) pattern[k] = '0;
         foreach (window[k]) window[k] = '0;
         care      = CARE_MASK_RESET;
         length    = '0;
         hit_limit = MAX_HITS_RESET;
         fill      = 0;
         next_addr = '0;
         region    = '0;
         hit_count = '0;
      endfunction

      function void apply_register(input logic [CSR_IDX_W-1:0] index,
                                   input bit [CSR_W-1:0] value);
         case (index)
            REG_PATTERN_LOW: begin
               for (int k = 0; k < 8; k++) pattern[k] = value[8*k +: 8];
            end
            REG_PATTERN_HIGH: begin
               for (int k = 0; k < 8; k++) pattern[k+8] = value[8*k +: 8];
            end
            REG_CARE_MASK:   care = value[PATTERN_BYTES-1:0];
            REG_PATTERN_LEN: length = value[LEN_W-1:0];
            REG_MAX_HITS:    hit_limit = value[HITS_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_byte(input bit [DATA_W-1:0] data, input bit starts_region,
                              input bit [BASE_W-1:0] base, input bit [REGION_W-1:0] number);
         bit [BASE_W-1:0] addr;
         bit              matched;
         scan_hit_type    hit;
         if (starts_region) begin
            fill      = 0;
            next_addr = base;
            region    = number;
         end
         addr = next_addr;
         for (int k = 0; k < WINDOW - 1; k++) window[k] = window[k+1];
         window[WINDOW-1] = data;
         if (fill < WINDOW) fill++;
         next_addr = addr + 1'b1;

         if (length == 0 || length > WINDOW || fill < length || hit_count >= hit_limit)
            return;
         matched = 1'b1;
         for (int k = 0; k < length; k++) begin
            // Positions past the sixteen register bytes would be wildcards.
            if (k < PATTERN_BYTES && care[k] && pattern[k] != window[WINDOW-length+k])
               matched = 1'b0;
         end
         if (!matched) return;

         hit_count++;
         hit.address = addr - (BASE_W'(length) - 1'b1);
         hit.region  = region;
         expected_hits.insert(expected_hits.size(), hit);
      endfunction

      task report(input string what);
         mismatches++;
         $display("ERROR at %0t ns: %s", $time, what);
      endtask

      task check_hit(input logic [RSP_TDATA_W-1:0] tdata);
         scan_hit_type want;
         if (expected_hits.size() == 0) begin
            report($sformatf("hit at %h in region %h with no hit expected",
                             tdata[47:0], tdata[63:48]));
            return;
         end
         want = expected_hits.pop_front();
         hits_checked++;
         if (tdata[47:0] !== want.address)
            report($sformatf("hit_address %h, expected %h", tdata[47:0], want.address));
         if (tdata[63:48] !== want.region)
            report($sformatf("hit_region %h, expected %h", tdata[63:48], want.region));
      endtask
   endclass

   logic                    clock;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [REQ_TDATA_W-1:0]  req_tdata;
   logic                    req_tuser;
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic [RSP_TDATA_W-1:0]  rsp_tdata;
   logic                    csr_we;
   logic [CSR_IDX_W-1:0]    csr_index;
   logic [CSR_W-1:0]        csr_wdata;

   hit_scoreboard_type sb;
   bit            steady;
   int unsigned   bytes_sent;
   int unsigned   regions_sent;
   int unsigned   settings_used;
   int unsigned   idle_cycles;

   masked_byte_pattern_scanner i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            sb.note_byte(req_tdata[7:0], req_tuser, req_tdata[55:8], req_tdata[71:56]);
         if (rsp_tvalid && rsp_tready)
            sb.check_hit(rsp_tdata);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Watchdog: nothing moved for %0d cycles", IDLE_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // Response back-pressure: runs of readiness broken by short, and now and
   // then long, stalls.
   initial begin : response_pacing
      int unsigned run;
      int unsigned stall;
      rsp_tready = 1'b0;
      @(negedge clock);
      forever begin
         run   = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 30);
         stall = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 50) : $urandom_range(1, 3);
         rsp_tready <= 1'b1;
         repeat (run) @(negedge clock);
         rsp_tready <= 1'b0;
         repeat (stall) @(negedge clock);
      end
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (steady || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic bit [BASE_W-1:0] random_address();
      return {16'($urandom), 32'($urandom)};
   endfunction

   task automatic send_byte(input bit [DATA_W-1:0] data, input bit starts_region,
                            input bit [BASE_W-1:0] base, input bit [REGION_W-1:0] number);
      int unsigned gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {number, base, data};
      req_tuser  <= starts_region;
      @(posedge clock);
      while (req_tready !== 1'b1) @(posedge clock);
      bytes_sent++;
   endtask

   // Sends a region whose contents hold planted copies of the pattern among
   // filler bytes, so that well-formed windows reach the compare.
   task automatic send_region(input int unsigned size);
      bit [DATA_W-1:0]   contents [$];
      bit [BASE_W-1:0]   base;
      bit [REGION_W-1:0] number;
      int unsigned       flavour;
      int unsigned       plen;
      flavour = $urandom_range(0, 2);
      plen    = sb.length;
      steady  = ($urandom_range(0, 5) == 0);
      while (contents.size() < size) begin
         if (plen != 0 && plen <= PATTERN_BYTES && contents.size() + plen <= size
             && $urandom_range(0, 3) == 0) begin
            for (int j = 0; j < plen; j++)
               contents.insert(contents.size(),
                               sb.care[j] ? sb.pattern[j] : DATA_W'($urandom));
         end else begin
            case (flavour)
               0:       contents.insert(contents.size(), DATA_W'($urandom));
               1:       contents.insert(contents.size(),
                                        sb.pattern[$urandom_range(0, PATTERN_BYTES-1)]);
               default: contents.insert(contents.size(),
                                        $urandom_range(0, 1) ? 8'hFF : 8'h00);
            endcase
         end
      end
      base = ($urandom_range(0, 4) == 0) ? 48'hFFFF_FFFF_FFFF - $urandom_range(0, 20)
                                         : random_address();
      case ($urandom_range(0, 9))
         0:       number = '0;
         1:       number = '1;
         default: number = REGION_W'($urandom);
      endcase
      foreach (contents[j]) begin
         if (j == 0) send_byte(contents[j], 1'b1, base, number);
         else        send_byte(contents[j], 1'b0, random_address(), REGION_W'($urandom));
      end
      regions_sent++;
   endtask

   // Lets the scanner run dry before its registers are touched.
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.expected_hits.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] index, input bit [CSR_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      sb.apply_register(index, value);
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic configure(input bit [63:0] low, input bit [63:0] high,
                            input bit [PATTERN_BYTES-1:0] care, input bit [LEN_W-1:0] len,
                            input bit [HITS_W-1:0] limit);
      settle();
      write_register(REG_PATTERN_LOW, low);
      write_register(REG_PATTERN_HIGH, high);
      write_register(REG_CARE_MASK, CSR_W'(care));
      write_register(REG_PATTERN_LEN, CSR_W'(len));
      write_register(REG_MAX_HITS, CSR_W'(limit));
      settings_used++;
   endtask

   initial begin : stimulus
      bit [LEN_W-1:0]         plen;
      bit [PATTERN_BYTES-1:0] mask;
      bit [HITS_W-1:0]        limit;
      int unsigned            r;
      int unsigned            phase_start;
      sb           = new();
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = 1'b0;
      csr_we       = 1'b0;
      csr_index    = '0;
      csr_wdata    = '0;
      steady       = 1'b0;
      bytes_sent   = 0;
      regions_sent = 0;
      settings_used = 0;
      idle_cycles  = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Bytes ahead of any region belong to region zero at address zero.
      configure(64'h0000_0000_0000_FF00, 64'h0, 16'hFFFF, 5'd2, 24'hFFFFFF);
      send_byte(8'h00, 1'b0, random_address(), REGION_W'($urandom));
      send_byte(8'hFF, 1'b0, random_address(), REGION_W'($urandom));

      // A zero pattern length never hits, even on matching bytes.
      configure(64'h0000_0000_0000_FF00, 64'h0, 16'hFFFF, 5'd0, 24'hFFFFFF);
      send_byte(8'h00, 1'b1, 48'h0, 16'h0);
      send_byte(8'hFF, 1'b0, random_address(), REGION_W'($urandom));

      // Full-length pattern with wildcard ends, in a region that wraps the
      // address space.
      configure(64'hA5A5_A5A5_A5A5_A5A5, 64'hA5A5_A5A5_A5A5_A5A5, 16'h7FFE, 5'd16, 24'd2);
      for (int j = 0; j < 16; j++) begin
         if (j == 0)       send_byte(8'h00, 1'b1, 48'hFFFF_FFFF_FFF8, 16'hFFFF);
         else if (j == 15) send_byte(8'hFF, 1'b0, random_address(), REGION_W'($urandom));
         else              send_byte(8'hA5, 1'b0, random_address(), REGION_W'($urandom));
      end

      // Hit limit already reached stays silent; raising it resumes the hits.
      configure(64'h0, 64'h0, 16'h0000, 5'd1, 24'd2);
      repeat (2) send_byte(DATA_W'($urandom), 1'b0, random_address(), REGION_W'($urandom));
      configure(64'h0, 64'h0, 16'h0000, 5'd1, 24'd4);
      repeat (3) send_byte(DATA_W'($urandom), 1'b0, random_address(), REGION_W'($urandom));

      for (int phase = 0; phase < PHASES; phase++) begin
         r = $urandom_range(0, 9);
         if (r == 0)      plen = 5'd0;
         else if (r == 1) plen = 5'd16;
         else if (r == 2) plen = LEN_W'($urandom_range(17, 31));
         else             plen = LEN_W'($urandom_range(1, 8));
         r = $urandom_range(0, 7);
         if (r < 2)       mask = 16'hFFFF;
         else if (r == 2) mask = 16'h0000;
         else             mask = PATTERN_BYTES'($urandom | $urandom);
         r = $urandom_range(0, 11);
         if (r == 0)      limit = '0;
         else if (r < 3)  limit = sb.hit_count + HITS_W'($urandom_range(0, 5));
         else             limit = 24'hFFFFFF;
         if (phase == 0) begin
            plen = 5'd16;
            mask = 16'hFFFF;
         end
         if (phase == 1) mask = 16'h0000;
         if (phase == 2) limit = '0;
         if (phase == 3) plen = 5'd31;
         if (phase == PHASES - 1) limit = 24'hFFFFFF;
         configure({$urandom, $urandom}, {$urandom, $urandom}, mask, plen, limit);

         phase_start = bytes_sent;
         // Sometimes the window carries the previous region across the change.
         if ($urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 6))
               send_byte(DATA_W'($urandom), 1'b0, random_address(), REGION_W'($urandom));
         while (bytes_sent - phase_start < PHASE_SIZE) begin
            if ($urandom_range(0, 4) == 0) begin
               steady = 1'b0;
               repeat ($urandom_range(1, 10))
                  send_byte(DATA_W'($urandom), $urandom_range(0, 7) == 0,
                            random_address(), REGION_W'($urandom));
            end else if ($urandom_range(0, 5) == 0) begin
               send_region($urandom_range(1, 3));
            end else begin
               send_region($urandom_range(1, 40));
            end
         end
      end

      settle();
      repeat (8) @(posedge clock);
      if (sb.expected_hits.size() != 0)
         sb.report($sformatf("%0d expected hits never arrived", sb.expected_hits.size()));
      $display("Scanned %0d bytes in %0d regions under %0d register settings.",
               bytes_sent, regions_sent, settings_used);
      $display("Checked %0d hits, with wildcards, address wrap and hit limits exercised.",
               sb.hits_checked);
      if (sb.mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
